@@ rtl/core/dtg_pkg.sv @@
// ----------------------------------------------------------------------------
// dtg_pkg
// Shared types, constants and the quarter-wave sine function of the decaying
// tone generator.
// ----------------------------------------------------------------------------
package dtg_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAG_BITS       = 15;
    localparam int ENV_BITS       = 32;
    localparam int PINC_BITS      = 31;
    localparam int LEN_BITS       = 20;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [MAG_BITS-1:0]  MAG_FULL         = 15'd32767;
    localparam logic [PINC_BITS-1:0] PINC_RESET       = 31'd50935780;
    localparam logic [ENV_BITS-1:0]  ENV_DEC_RESET    = 32'd243479;
    localparam logic [LEN_BITS-1:0]  TONE_LEN_RESET   = 20'd17640;
    localparam logic [ENV_BITS-1:0]  ENV_FULL         = 32'hFFFF_FFFF;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_INC = 3'd0,
        CFG_ENV_DEC   = 3'd1,
        CFG_TONE_LEN  = 3'd2,
        CFG_WAVEFORM  = 3'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MULT,
        ST_EMIT
    } dtg_state_t;

    typedef struct packed {
        logic load;
        logic rom_read;
        logic multiply;
        logic emit;
    } dtg_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dtg_status_t;

    // Q30 Taylor series of sin((pi/2) * k / 2^abits), rounded to 0..32767.
    function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned k,
                                                         input int unsigned abits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x    = (HALF_PI_Q30 * 64'(k)) >> abits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        if (sum > $signed(Q30_ONE))
        begin
            sum = $signed(Q30_ONE);
        end
        scaled = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        return scaled[MAG_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/dtg_if.sv @@
// ----------------------------------------------------------------------------
// dtg channel interfaces
// Tick request, sample result and configuration write channels.
// ----------------------------------------------------------------------------
interface dtg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface dtg_out_if;
    import dtg_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          active;

    modport source (output valid, output sample, output last, output active, input ready);
    modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

interface dtg_cfg_if;
    import dtg_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/decaying_tone_generator.sv @@
// ----------------------------------------------------------------------------
// decaying_tone_generator
// Phase-accumulator tone source with a quarter-wave sine ROM, optional square
// wave, and a linear decay envelope.
//
// tick: one word per audio sample; restart=1 starts the tone over at its
//   first sample, restart=0 advances one sample.
// wave: one word back per tick: signed sample, last flag on the final sample
//   of the tone, active while the tone sounds. Once the tone has ended every
//   tick gives a zero, inactive word until the next restart.
// cfg: register writes (0 phase increment, 1 envelope step, 2 tone length,
//   3 waveform) taken every cycle; write only while no tick is in flight.
// Sequence: an accepted tick is loaded, then the sequencer reads the ROM,
//   multiplies by the envelope and emits the word; a new tick is taken only
//   once the last one is emitted. The result register lets the next tick
//   in while a word waits, a stalled receiver holds the block after that.
// Reset: configuration to defaults, tone silent until a restart tick.
// ----------------------------------------------------------------------------
module decaying_tone_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COUNT_BITS      = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    dtg_in_if.sink    tick,
    dtg_out_if.source wave,
    dtg_cfg_if.sink   cfg
);
    import dtg_pkg::*;

    dtg_cmd_t    cmd;
    dtg_status_t status;
    logic        in_ready;

    assign tick.ready = in_ready;

    dtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tick.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dtg_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (tick.restart),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .res     (wave)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> !tick.ready)
        else $error("tick accepted while a word is in flight");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wave.valid && !wave.active |-> wave.sample == 0 && !wave.last)
        else $error("silent word carries data");

    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        wave.valid && wave.last |-> wave.active)
        else $error("last flag on inactive word");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready && !(wave.valid && !wave.ready) |=> ##3 wave.valid)
        else $error("word not produced in time");
`endif

endmodule

@@ rtl/core/dtg_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtg_ctrl
// Sequencer: accept a tick, read the sine ROM, scale by the envelope, emit.
// ----------------------------------------------------------------------------
module dtg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dtg_pkg::dtg_status_t status,
    output dtg_pkg::dtg_cmd_t    cmd
);
    import dtg_pkg::*;

    dtg_state_t state_reg;
    dtg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rom_read = 1'b1;
                state_next   = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.multiply = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/dtg_datapath.sv @@
// ----------------------------------------------------------------------------
// dtg_datapath
// Configuration registers, phase/envelope/count state, sine ROM, envelope
// multiplier and the output word register.
// ----------------------------------------------------------------------------
module dtg_datapath #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COUNT_BITS      = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  dtg_pkg::dtg_cmd_t    cmd,
    output dtg_pkg::dtg_status_t status,
    dtg_cfg_if.sink              cfg,
    dtg_out_if.source            res
);
    import dtg_pkg::*;

    localparam int QUARTER  = 1 << TABLE_ADDR_BITS;
    localparam int CMP_BITS = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
    localparam int PROD_BITS = MAG_BITS + ENV_BITS + 1;
    localparam logic [TABLE_ADDR_BITS:0] QUARTER_ADDR = {1'b1, {TABLE_ADDR_BITS{1'b0}}};
    localparam logic [COUNT_BITS-1:0]    COUNT_MAX    = '1;

    typedef logic [MAG_BITS-1:0] rom_t [0:QUARTER];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= QUARTER; k++)
        begin
            r[k] = quarter_sine(k, TABLE_ADDR_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration
    logic [PINC_BITS-1:0] phase_inc_reg;
    logic [ENV_BITS-1:0]  env_dec_reg;
    logic [LEN_BITS-1:0]  tone_len_reg;
    logic                 waveform_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= PINC_RESET;
            env_dec_reg   <= ENV_DEC_RESET;
            tone_len_reg  <= TONE_LEN_RESET;
            waveform_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PHASE_INC: phase_inc_reg <= cfg.data[PINC_BITS-1:0];
                CFG_ENV_DEC:   env_dec_reg   <= cfg.data[ENV_BITS-1:0];
                CFG_TONE_LEN:  tone_len_reg  <= cfg.data[LEN_BITS-1:0];
                CFG_WAVEFORM:  waveform_reg  <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // tone state
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [ENV_BITS-1:0]   env_reg;
    logic [ENV_BITS-1:0]   env_next;
    logic [COUNT_BITS-1:0] index_reg;
    logic [COUNT_BITS-1:0] index_next;
    logic                  finished_reg;
    logic                  finished_next;

    logic [PHASE_BITS-1:0]      eff_phase;
    logic [ENV_BITS-1:0]        eff_env;
    logic [COUNT_BITS-1:0]      eff_index;
    logic                       eff_finished;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [CMP_BITS-1:0]        index_plus;
    logic                       last_now;

    assign eff_phase    = restart ? '0 : phase_reg;
    assign eff_env      = restart ? ENV_FULL : env_reg;
    assign eff_index    = restart ? '0 : index_reg;
    assign eff_finished = restart ? 1'b0 : finished_reg;

    assign quad       = eff_phase[PHASE_BITS-1 -: 2];
    assign addr       = eff_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign index_plus = CMP_BITS'(eff_index) + CMP_BITS'(1);
    assign last_now   = (index_plus >= CMP_BITS'(tone_len_reg)) || (eff_index == COUNT_MAX);

    always_comb
    begin
        phase_next    = phase_reg;
        env_next      = env_reg;
        index_next    = index_reg;
        finished_next = finished_reg;
        if (cmd.load && !eff_finished)
        begin
            phase_next    = eff_phase + PHASE_BITS'(phase_inc_reg);
            env_next      = (eff_env > env_dec_reg) ? (eff_env - env_dec_reg) : '0;
            index_next    = (eff_index == COUNT_MAX) ? eff_index : eff_index + 1'b1;
            finished_next = last_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            env_reg      <= ENV_FULL;
            index_reg    <= '0;
            finished_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            env_reg      <= env_next;
            index_reg    <= index_next;
            finished_reg <= finished_next;
        end
    end

    // per-word pipeline registers
    logic [TABLE_ADDR_BITS:0] rom_addr_reg;
    logic                     neg_reg;
    logic [ENV_BITS-1:0]      env_word_reg;
    logic                     last_reg;
    logic                     silent_reg;
    logic [MAG_BITS-1:0]      rom_data_reg;
    logic [MAG_BITS-1:0]      scaled_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rom_addr_reg <= quad[0] ? (QUARTER_ADDR - {1'b0, addr}) : {1'b0, addr};
            neg_reg      <= quad[1];
            env_word_reg <= eff_env;
            last_reg     <= last_now;
            silent_reg   <= eff_finished;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rom_read)
        begin
            rom_data_reg <= SINE_ROM[rom_addr_reg];
        end
    end

    logic [MAG_BITS-1:0]  mag;
    logic [ENV_BITS:0]    env_plus;
    logic [PROD_BITS-1:0] prod;

    assign mag      = waveform_reg ? MAG_FULL : rom_data_reg;
    assign env_plus = {1'b0, env_word_reg} + 1'b1;
    assign prod     = PROD_BITS'(mag) * PROD_BITS'(env_plus);

    always_ff @(posedge clk)
    begin
        if (cmd.multiply)
        begin
            scaled_reg <= prod[ENV_BITS +: MAG_BITS];
        end
    end

    // output word
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_last_reg;
    logic                   out_active_reg;
    logic [SAMPLE_BITS-1:0] sample_next;

    assign sample_next = silent_reg ? '0 :
                         (neg_reg ? (SAMPLE_BITS'(0) - {1'b0, scaled_reg}) : {1'b0, scaled_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sample_reg     <= sample_next;
            out_last_reg   <= !silent_reg && last_reg;
            out_active_reg <= !silent_reg;
        end
    end

    assign res.valid  = out_valid_reg;
    assign res.sample = $signed(sample_reg);
    assign res.last   = out_last_reg;
    assign res.active = out_active_reg;

    assign status.out_stall = out_valid_reg && !res.ready;

endmodule
